@@ sv/cc20_pkg.sv @@
// ----------------------------------------------------------------------------
// cc20_pkg
// shared types, constants and helpers of the byte-stream chacha20 cipher
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam int unsigned DoubleRoundsDef = 10;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned MemDepth = 32;
  localparam int unsigned MemAw    = $clog2(MemDepth);
  localparam int unsigned KsBase   = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [WordW-1:0] Sigma0 = 32'h61707865;
  localparam logic [WordW-1:0] Sigma1 = 32'h3320646e;
  localparam logic [WordW-1:0] Sigma2 = 32'h79622d32;
  localparam logic [WordW-1:0] Sigma3 = 32'h6b206574;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKey0     = 3'd0,
    CfgKey1     = 3'd1,
    CfgKey2     = 3'd2,
    CfgKey3     = 3'd3,
    CfgNonceLo  = 3'd4,
    CfgNonceHi  = 3'd5,
    CfgStartCtr = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StInit,
    StRd0,
    StRd1,
    StCap,
    StStep,
    StWr,
    StFin,
    StKsRd,
    StOut
  } cc20_state_e;

  // one write port, two read ports
  typedef struct packed {
    logic             we;
    logic [MemAw-1:0] waddr;
    logic [MemAw-1:0] raddr0;
    logic [MemAw-1:0] raddr1;
  } ram_req_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (WordW - n));
  endfunction

  // state word of role a/b/c/d (0..3) for quarter round q of a double round
  function automatic logic [3:0] qr_index(input logic [2:0] q, input logic [1:0] role);
    logic [1:0] col;
    col = q[1:0] + (q[2] ? role : 2'd0);
    qr_index = {role, col};
  endfunction

endpackage

@@ sv/cc20_in_if.sv @@
// ----------------------------------------------------------------------------
// cc20_in_if
// input byte channel: data byte and end-of-message mark
// ----------------------------------------------------------------------------
interface cc20_in_if import cc20_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             message_end;

  modport source (output valid, output data_byte, output message_end, input ready);
  modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

@@ sv/cc20_out_if.sv @@
// ----------------------------------------------------------------------------
// cc20_out_if
// result byte channel: transformed byte and end-of-message mark
// ----------------------------------------------------------------------------
interface cc20_out_if import cc20_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] result_byte;
  logic             last;

  modport source (output valid, output result_byte, output last, input ready);
  modport sink   (input valid, input result_byte, input last, output ready);
endinterface

@@ sv/cc20_cfg_if.sv @@
// ----------------------------------------------------------------------------
// cc20_cfg_if
// register write channel: register index and write data
// ----------------------------------------------------------------------------
interface cc20_cfg_if import cc20_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/cc20_ram.sv @@
// ----------------------------------------------------------------------------
// cc20_ram
// state memory: working state in the lower half, keystream in the upper half
// ----------------------------------------------------------------------------
module cc20_ram import cc20_pkg::*; (
  input  logic             clk_i,
  input  ram_req_t         req_i,
  input  logic [WordW-1:0] wdata_i,
  output logic [WordW-1:0] rdata0_o,
  output logic [WordW-1:0] rdata1_o
);

  logic [WordW-1:0] mem_q [MemDepth];
  logic [WordW-1:0] rdata0_q;
  logic [WordW-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= wdata_i;
    end
    rdata0_q <= mem_q[req_i.raddr0];
    rdata1_q <= mem_q[req_i.raddr1];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

@@ sv/chacha20_stream_cipher.sv @@
// while a keystream block is held, an accepted byte goes through StOut to the output
// register, and no new byte is taken until StIdle; a new block first runs StInit, the
// double rounds and StFin, each quarter round writing back through the single write port;
// reset clears key, nonce and counter to zero and drops the held block;
// the state memory is not cleared and is only read after it is written
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// byte-stream chacha20, keystream block generated in a shared state memory
// ----------------------------------------------------------------------------
module chacha20_stream_cipher import cc20_pkg::*; #(
  parameter int unsigned DOUBLE_ROUNDS = DoubleRoundsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cc20_cfg_if.sink   cfg_i,
  cc20_in_if.sink    in_i,
  cc20_out_if.source out_o
);

  localparam int unsigned RndW = $clog2(DOUBLE_ROUNDS);

  // configuration
  logic [3:0][CfgDataW-1:0] key_q;
  logic [CfgDataW-1:0]      nonce_lo_q;
  logic [WordW-1:0]         nonce_hi_q;
  logic [WordW-1:0]         ctr_q;
  logic [WordW-1:0]         ctr_d;

  // control
  cc20_state_e     state_q, state_d;
  logic [2:0]      qr_q, qr_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [6:0]      pos_q, pos_d;
  logic            valid_q, valid_d;
  logic            out_valid_q, out_valid_d;

  // payload
  logic [WordW-1:0] a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [ByteW-1:0] hold_byte_q, hold_byte_d;
  logic             hold_last_q, hold_last_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;

  ram_req_t         ram_req;
  logic [WordW-1:0] ram_wdata;
  logic [WordW-1:0] ram_rdata0;
  logic [WordW-1:0] ram_rdata1;

  logic [15:0][WordW-1:0] init_w;
  logic [WordW-1:0]       sum_w;
  logic [WordW-1:0]       ks_word;
  logic [3:0]             fin_prev;
  logic                   need_blk;
  logic                   in_fire;
  logic                   out_fire;

  cc20_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .wdata_i (ram_wdata),
    .rdata0_o(ram_rdata0),
    .rdata1_o(ram_rdata1)
  );

  // initial state words
  always_comb begin
    init_w[0]  = Sigma0;
    init_w[1]  = Sigma1;
    init_w[2]  = Sigma2;
    init_w[3]  = Sigma3;
    for (int k = 0; k < 4; k++) begin
      init_w[4 + 2 * k] = key_q[k][WordW-1:0];
      init_w[5 + 2 * k] = key_q[k][CfgDataW-1:WordW];
    end
    init_w[12] = ctr_q;
    init_w[13] = nonce_lo_q[WordW-1:0];
    init_w[14] = nonce_lo_q[CfgDataW-1:WordW];
    init_w[15] = nonce_hi_q;
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= '0;
      nonce_lo_q <= '0;
      nonce_hi_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgKey0:    key_q[0]   <= cfg_i.data;
        CfgKey1:    key_q[1]   <= cfg_i.data;
        CfgKey2:    key_q[2]   <= cfg_i.data;
        CfgKey3:    key_q[3]   <= cfg_i.data;
        CfgNonceLo: nonce_lo_q <= cfg_i.data;
        CfgNonceHi: nonce_hi_q <= cfg_i.data[WordW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign need_blk = !valid_q || pos_q[6];
  assign in_i.ready = (state_q == StIdle) && (!out_valid_q || out_o.ready);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign fin_prev = 4'(cnt_q - 5'd1);
  assign ks_word  = ram_rdata0 >> {pos_q[1:0], 3'b000};

  always_comb begin
    state_d     = state_q;
    qr_d        = qr_q;
    rnd_d       = rnd_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    valid_d     = valid_q;
    ctr_d       = ctr_q;
    out_valid_d = out_valid_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    hold_byte_d = hold_byte_q;
    hold_last_d = hold_last_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    sum_w       = '0;

    ram_req.we     = 1'b0;
    ram_req.waddr  = '0;
    ram_req.raddr0 = MemAw'(KsBase) + MemAw'(pos_q[5:2]);
    ram_req.raddr1 = '0;
    ram_wdata      = '0;

    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (cfg_i.valid && (cfg_i.index == CfgStartCtr)) begin
      ctr_d = cfg_i.data[WordW-1:0];
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          hold_byte_d = in_i.data_byte;
          hold_last_d = in_i.message_end;
          if (need_blk) begin
            cnt_d   = '0;
            state_d = StInit;
          end else begin
            state_d = StOut;
          end
        end
      end
      StInit: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = MemAw'(cnt_q[3:0]);
        ram_wdata     = init_w[cnt_q[3:0]];
        cnt_d         = cnt_q + 5'd1;
        if (cnt_q[3:0] == 4'd15) begin
          qr_d    = '0;
          rnd_d   = '0;
          state_d = StRd0;
        end
      end
      StRd0: begin
        ram_req.raddr0 = MemAw'(qr_index(qr_q, 2'd0));
        ram_req.raddr1 = MemAw'(qr_index(qr_q, 2'd1));
        state_d        = StRd1;
      end
      StRd1: begin
        a_d            = ram_rdata0;
        b_d            = ram_rdata1;
        ram_req.raddr0 = MemAw'(qr_index(qr_q, 2'd2));
        ram_req.raddr1 = MemAw'(qr_index(qr_q, 2'd3));
        state_d        = StCap;
      end
      StCap: begin
        c_d     = ram_rdata0;
        d_d     = ram_rdata1;
        cnt_d   = '0;
        state_d = StStep;
      end
      StStep: begin
        // one add, xor and rotate of the quarter round per cycle
        unique case (cnt_q[1:0])
          2'd0: begin
            sum_w = a_q + b_q;
            a_d   = sum_w;
            d_d   = rotl(d_q ^ sum_w, 16);
          end
          2'd1: begin
            sum_w = c_q + d_q;
            c_d   = sum_w;
            b_d   = rotl(b_q ^ sum_w, 12);
          end
          2'd2: begin
            sum_w = a_q + b_q;
            a_d   = sum_w;
            d_d   = rotl(d_q ^ sum_w, 8);
          end
          default: begin
            sum_w = c_q + d_q;
            c_d   = sum_w;
            b_d   = rotl(b_q ^ sum_w, 7);
          end
        endcase
        cnt_d = cnt_q + 5'd1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d   = '0;
          state_d = StWr;
        end
      end
      StWr: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = MemAw'(qr_index(qr_q, cnt_q[1:0]));
        unique case (cnt_q[1:0])
          2'd0:    ram_wdata = a_q;
          2'd1:    ram_wdata = b_q;
          2'd2:    ram_wdata = c_q;
          default: ram_wdata = d_q;
        endcase
        cnt_d = cnt_q + 5'd1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d = '0;
          qr_d  = qr_q + 3'd1;
          if (qr_q == 3'd7) begin
            if (rnd_q == RndW'(DOUBLE_ROUNDS - 1)) begin
              state_d = StFin;
            end else begin
              rnd_d   = rnd_q + RndW'(1);
              state_d = StRd0;
            end
          end else begin
            state_d = StRd0;
          end
        end
      end
      StFin: begin
        // read word n while word n-1 plus its initial value goes to the keystream
        ram_req.raddr0 = MemAw'(cnt_q[3:0]);
        if (cnt_q != 5'd0) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = MemAw'(KsBase) + MemAw'(fin_prev);
          ram_wdata     = ram_rdata0 + init_w[fin_prev];
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          valid_d = 1'b1;
          pos_d   = '0;
          ctr_d   = ctr_q + 32'd1;
          state_d = StKsRd;
        end
      end
      StKsRd: begin
        state_d = StOut;
      end
      StOut: begin
        out_byte_d  = hold_byte_q ^ ks_word[ByteW-1:0];
        out_last_d  = hold_last_q;
        out_valid_d = 1'b1;
        pos_d       = pos_q + 7'd1;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      qr_q        <= '0;
      rnd_q       <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      valid_q     <= 1'b0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      qr_q        <= qr_d;
      rnd_q       <= rnd_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      valid_q     <= valid_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    b_q         <= b_d;
    c_q         <= c_d;
    d_q         <= d_d;
    hold_byte_q <= hold_byte_d;
    hold_last_q <= hold_last_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_byte = out_byte_q;
  assign out_o.last        = out_last_q;

endmodule
